[hw/rtl/cte_pkg.sv]
// Shared types, codes and constants of the claim table engine.
package cte_pkg;

    localparam int ENTRIES_DEF = 16;

    // Operation codes.
    localparam logic [2:0] OP_ADD        = 3'd0;
    localparam logic [2:0] OP_REM_HANDLE = 3'd1;
    localparam logic [2:0] OP_REM_OWNER  = 3'd2;
    localparam logic [2:0] OP_EXPIRE     = 3'd3;
    localparam logic [2:0] OP_QUERY      = 3'd4;
    localparam logic [2:0] OP_CLEAR      = 3'd5;

    // Claim kinds and their priorities.
    localparam logic [1:0] KIND_HARD = 2'd0;
    localparam logic [1:0] KIND_SOFT = 2'd1;
    localparam logic [1:0] KIND_SPEC = 2'd2;
    localparam logic [1:0] PRIO_HARD = 2'd3;
    localparam logic [1:0] PRIO_SOFT = 2'd2;
    localparam logic [1:0] PRIO_SPEC = 2'd1;
    localparam logic [1:0] PRIO_NONE = 2'd0;

    localparam logic [1:0]  WEAKEST_RESET = KIND_SPEC;
    localparam logic [31:0] HANDLE_FIRST  = 32'd1;
    localparam logic [31:0] HANDLE_LAST   = 32'hFFFF_FFFF;
    localparam logic [4:0]  COUNT_SAT     = 5'd31;
    localparam logic [31:0] EXPIRY_NEVER  = 32'd0;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] cell_req;
        logic [31:0] domains;
        logic [1:0]  kind;
        logic [31:0] owner;
        logic [31:0] expires_at;
        logic [31:0] handle;
        logic [31:0] now_tick;
    } cte_in_t;

    typedef struct packed {
        logic [31:0] new_handle;
        logic        table_full;
        logic        found;
        logic [4:0]  removed_count;
        logic        holds;
        logic [1:0]  priority_res;
    } cte_out_t;

    typedef struct packed {
        logic [31:0] cell_key;
        logic [31:0] domains;
        logic [1:0]  kind;
        logic [31:0] owner;
        logic [31:0] expiry;
        logic [31:0] handle;
    } cte_entry_t;

    typedef struct packed {
        logic       handle_hit;
        logic       owner_hit;
        logic       expire_hit;
        logic [1:0] prio;
    } cte_match_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_WALK,
        ST_DONE
    } cte_state_t;

endpackage

[hw/rtl/claim_table_engine_core.sv]
// Claim table engine top level: sequencer, valid bits, handle counter and result register.
// Add scans the valid bits for the lowest free entry and reports a full table if none is free;
// remove by handle, remove by owner, expire and query walk the entry memory one entry per cycle
// through its registered read port (a handle hit ends early); clear and unknown operations go
// straight to the result. One request is in work at a time: the next one is taken in the cycle
// after the result is posted, later while an earlier result still waits on the output.
// Reset clears the valid bits at once, sets the handle counter to 1 and the honored kind to
// speculative; entry contents are not cleared.
module claim_table_engine_core #(
    parameter int ENTRIES = cte_pkg::ENTRIES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    // Request channel.
    input  logic              s_valid,
    output logic              s_ready,
    input  cte_pkg::cte_in_t  s_data,
    // Result channel.
    output logic              m_valid,
    input  logic              m_ready,
    output cte_pkg::cte_out_t m_data,
    // Configuration write channel for the weakest honored kind.
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_data
);

    // Entry index width, and a walk counter wide enough to hold ENTRIES itself.
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    cte_pkg::cte_state_t state_reg, state_next;
    logic [ENTRIES-1:0]  valid_reg, valid_next;
    logic [31:0]         handle_reg, handle_next;
    logic [1:0]          weakest_reg, weakest_next;
    cte_pkg::cte_in_t    req_reg, req_next;
    cte_pkg::cte_out_t   res_reg, res_next;
    logic [IDX_W-1:0]    add_idx_reg, add_idx_next;
    logic [CNT_W-1:0]    rd_cnt_reg, rd_cnt_next;
    logic                cmp_live_reg, cmp_live_next;
    logic [IDX_W-1:0]    cmp_idx_reg, cmp_idx_next;
    logic                m_valid_reg, m_valid_next;
    cte_pkg::cte_out_t   m_data_reg, m_data_next;

    logic                mem_we;
    cte_pkg::cte_entry_t mem_wdata;
    cte_pkg::cte_entry_t mem_rdata;
    cte_pkg::cte_match_t match;
    logic                walk_end;

    // The entry memory is read one address per cycle; the data for the entry addressed in
    // one cycle reaches the compare unit in the next, tracked by cmp_live/cmp_idx.
    cte_store #(
        .ENTRIES(ENTRIES)
    ) u_store (
        .aclk (aclk),
        .we   (mem_we),
        .waddr(add_idx_reg),
        .wdata(mem_wdata),
        .raddr(rd_cnt_reg[IDX_W-1:0]),
        .rdata(mem_rdata)
    );

    cte_unit u_unit (
        .entry  (mem_rdata),
        .req    (req_reg),
        .weakest(weakest_reg),
        .match  (match)
    );

    // A new claim takes the latched request; a kind of 3 is stored as speculative.
    always_comb begin
        mem_wdata.cell_key = req_reg.cell_req;
        mem_wdata.domains  = req_reg.domains;
        mem_wdata.kind     = (req_reg.kind > cte_pkg::KIND_SPEC) ? cte_pkg::KIND_SPEC
                                                                 : req_reg.kind;
        mem_wdata.owner    = req_reg.owner;
        mem_wdata.expiry   = req_reg.expires_at;
        mem_wdata.handle   = handle_reg;
    end

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == cte_pkg::ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign walk_end  = (rd_cnt_reg == CNT_W'(ENTRIES)) && !cmp_live_reg;

    always_comb begin
        state_next    = state_reg;
        valid_next    = valid_reg;
        handle_next   = handle_reg;
        weakest_next  = weakest_reg;
        req_next      = req_reg;
        res_next      = res_reg;
        add_idx_next  = add_idx_reg;
        rd_cnt_next   = rd_cnt_reg;
        cmp_live_next = 1'b0;
        cmp_idx_next  = rd_cnt_reg[IDX_W-1:0];
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        mem_we        = 1'b0;

        // A register value of 3 behaves as speculative, so it is stored clamped.
        if (cfg_valid) begin
            weakest_next = (cfg_data > cte_pkg::WEAKEST_RESET) ? cte_pkg::WEAKEST_RESET
                                                               : cfg_data;
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            cte_pkg::ST_IDLE: begin
                if (s_valid) begin
                    req_next     = s_data;
                    res_next     = '0;
                    add_idx_next = '0;
                    rd_cnt_next  = '0;
                    case (s_data.op)
                        cte_pkg::OP_ADD: begin
                            state_next = cte_pkg::ST_ADD;
                        end
                        cte_pkg::OP_REM_HANDLE, cte_pkg::OP_REM_OWNER,
                        cte_pkg::OP_EXPIRE, cte_pkg::OP_QUERY: begin
                            state_next = cte_pkg::ST_WALK;
                        end
                        cte_pkg::OP_CLEAR: begin
                            // The handle counter is kept across a clear.
                            valid_next = '0;
                            state_next = cte_pkg::ST_DONE;
                        end
                        default: begin
                            state_next = cte_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            // Scan the valid bits for the lowest free entry, one per cycle.
            cte_pkg::ST_ADD: begin
                if (!valid_reg[add_idx_reg]) begin
                    mem_we                 = 1'b1;
                    valid_next[add_idx_reg] = 1'b1;
                    res_next.new_handle    = handle_reg;
                    // Handle zero is never issued: the counter wraps back to one.
                    handle_next = (handle_reg == cte_pkg::HANDLE_LAST) ? cte_pkg::HANDLE_FIRST
                                                                       : handle_reg + 32'd1;
                    state_next  = cte_pkg::ST_DONE;
                end else if (add_idx_reg == IDX_W'(ENTRIES - 1)) begin
                    res_next.table_full = 1'b1;
                    state_next          = cte_pkg::ST_DONE;
                end else begin
                    add_idx_next = add_idx_reg + IDX_W'(1);
                end
            end

            // Walk the entries through the compare unit in ascending order; a remove by handle stops at its first hit.
            cte_pkg::ST_WALK: begin
                if (rd_cnt_reg != CNT_W'(ENTRIES)) begin
                    cmp_live_next = 1'b1;
                    rd_cnt_next   = rd_cnt_reg + CNT_W'(1);
                end
                if (walk_end) begin
                    state_next = cte_pkg::ST_DONE;
                end
                if (cmp_live_reg && valid_reg[cmp_idx_reg]) begin
                    case (req_reg.op)
                        cte_pkg::OP_REM_HANDLE: begin
                            // Only the lowest-numbered entry with the handle is removed.
                            if (match.handle_hit) begin
                                valid_next[cmp_idx_reg] = 1'b0;
                                res_next.found          = 1'b1;
                                state_next              = cte_pkg::ST_DONE;
                            end
                        end
                        cte_pkg::OP_REM_OWNER, cte_pkg::OP_EXPIRE: begin
                            if ((req_reg.op == cte_pkg::OP_REM_OWNER) ? match.owner_hit
                                                                      : match.expire_hit) begin
                                valid_next[cmp_idx_reg] = 1'b0;
                                if (res_reg.removed_count != cte_pkg::COUNT_SAT) begin
                                    res_next.removed_count = res_reg.removed_count + 5'd1;
                                end
                            end
                        end
                        cte_pkg::OP_QUERY: begin
                            if (match.prio > res_reg.priority_res) begin
                                res_next.priority_res = match.prio;
                                res_next.holds        = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Hand the result to the output register once it is free.
            cte_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = cte_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = cte_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= cte_pkg::ST_IDLE;
            valid_reg    <= '0;
            handle_reg   <= cte_pkg::HANDLE_FIRST;
            weakest_reg  <= cte_pkg::WEAKEST_RESET;
            rd_cnt_reg   <= '0;
            cmp_live_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            handle_reg   <= handle_next;
            weakest_reg  <= weakest_next;
            rd_cnt_reg   <= rd_cnt_next;
            cmp_live_reg <= cmp_live_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg     <= req_next;
        res_reg     <= res_next;
        add_idx_reg <= add_idx_next;
        cmp_idx_reg <= cmp_idx_next;
        m_data_reg  <= m_data_next;
    end

    // The handle counter never holds zero.
    assert property (@(posedge aclk) disable iff (!aresetn) handle_reg != 32'd0)
        else $error("handle counter reached zero");

    // A result reports holds exactly when it carries a nonzero priority.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.holds == (m_data_reg.priority_res != cte_pkg::PRIO_NONE)))
        else $error("holds and priority disagree");

    // A full-table add issues no handle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.table_full) |-> (m_data_reg.new_handle == 32'd0))
        else $error("handle issued on full table");

    // At most one claim is added per cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> ($countones(valid_reg) <= $past($countones(valid_reg)) + 1))
        else $error("more than one entry allocated in a cycle");

endmodule

[hw/rtl/cte_store.sv]
// Claim entry memory: one write port and one registered read port.
module cte_store #(
    parameter int ENTRIES = cte_pkg::ENTRIES_DEF
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] waddr,
    input  cte_pkg::cte_entry_t                    wdata,
    input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] raddr,
    output cte_pkg::cte_entry_t                    rdata
);

    cte_pkg::cte_entry_t mem [ENTRIES];
    cte_pkg::cte_entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/cte_unit.sv]
// Shared compare unit: checks one stored claim against the current request.
module cte_unit (
    input  cte_pkg::cte_entry_t entry,
    input  cte_pkg::cte_in_t    req,
    input  logic [1:0]          weakest,
    output cte_pkg::cte_match_t match
);

    logic honored;
    logic on_cell;

    always_comb begin
        honored = (entry.kind <= weakest);
        on_cell = (entry.cell_key == req.cell_req) && ((entry.domains & req.domains) != 32'd0);

        match.handle_hit = (entry.handle == req.handle);
        match.owner_hit  = (entry.owner == req.owner);
        match.expire_hit = (entry.expiry != cte_pkg::EXPIRY_NEVER) &&
                           (req.now_tick >= entry.expiry);
        match.prio       = cte_pkg::PRIO_NONE;
        if (honored && on_cell) begin
            case (entry.kind)
                cte_pkg::KIND_HARD: match.prio = cte_pkg::PRIO_HARD;
                cte_pkg::KIND_SOFT: match.prio = cte_pkg::PRIO_SOFT;
                default:            match.prio = cte_pkg::PRIO_SPEC;
            endcase
        end
    end

endmodule
